/* hdl/xoshiro_pkg.sv */
// package for the xoshiro256** random generator
// holds widths, generator and mixer constants and the sequencer state type
// no dependencies
package xoshiro_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned BOUND_W = 32;
    localparam int unsigned SPAN_W  = 33;
    localparam int unsigned PCT_W   = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned IDX_W   = 2;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 104;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] RESET_SEED  = 64'd1;
    localparam logic [SPAN_W-1:0] PERCENT_SPAN = 33'd100;

    localparam logic [CNT_W-1:0] ITER_LAST = 6'd63;
    localparam logic [IDX_W-1:0] WORD_LAST = 2'd3;

    localparam logic [KIND_W-1:0] KIND_RAW     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PERCENT = 2'd2;

    typedef enum logic [3:0] {
        ST_SEED_ADD,
        ST_MUL_A,
        ST_MIX_B,
        ST_MUL_B,
        ST_MIX_OUT,
        ST_IDLE,
        ST_SCRAMBLE,
        ST_DIV,
        ST_DONE
    } seq_state_t;

endpackage

/* hdl/xoshiro256ss_random_generator_top.sv */
// xoshiro256** generator: one raw, ranged or percent-chance result per beat
// a beat passes from the input through the scramble state to the result register for raw and unused kinds
// and empty ranges; ranged and percent beats also pass the 64-step radix-2 remainder loop first
// one beat is worked on at a time; a result waits in the done state while the output is stalled
// reset and every seed write run the splitmix64 expansion through a bit-serial
// multiplier with s_tready low; gen_reg itself has no reset
module xoshiro256ss_random_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        seed_wr_en,
    input  logic [63:0] seed_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // low_bound[31:0], high_bound[63:32], percent[71:64]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [103:0] m_tdata    // random_word[63:0], ranged_value[95:64], chance_hit[96], zeros
);

    xoshiro_pkg::seq_state_t state_reg, state_next;

    logic [63:0] gen_reg [0:3];
    logic [63:0] gen_next [0:3];
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  idx_reg, idx_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] mul_a_reg, mul_a_next;
    logic [63:0] mul_b_reg, mul_b_next;
    logic [63:0] prod_reg, prod_next;

    logic [1:0]  kind_reg, kind_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [7:0]  pct_reg, pct_next;
    logic [63:0] word_reg, word_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] divisor_reg, divisor_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] out_word_reg, out_word_next;
    logic [31:0] out_ranged_reg, out_ranged_next;
    logic        out_hit_reg, out_hit_next;

    logic [63:0] seed_sum;
    logic [63:0] mix_word;
    logic [63:0] rot_word;
    logic [33:0] div_shift;
    logic [34:0] div_diff;
    logic [63:0] g3_mix;
    logic        accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == xoshiro_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, out_hit_reg, out_ranged_reg, out_word_reg};

    assign seed_sum  = acc_reg + xoshiro_pkg::GOLDEN_STEP;
    assign mix_word  = prod_reg ^ (prod_reg >> 27);
    assign rot_word  = {word_reg[56:0], word_reg[63:57]};
    assign div_shift = {rem_reg, dvd_reg[63]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_reg};
    assign g3_mix    = gen_reg[3] ^ gen_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= xoshiro_pkg::ST_SEED_ADD;
            acc_reg      <= xoshiro_pkg::RESET_SEED;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            gen_reg[i] <= gen_next[i];
        end
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        prod_reg       <= prod_next;
        kind_reg       <= kind_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pct_reg        <= pct_next;
        word_reg       <= word_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        out_word_reg   <= out_word_next;
        out_ranged_reg <= out_ranged_next;
        out_hit_reg    <= out_hit_next;
    end

    always_comb begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        for (int i = 0; i < 4; i++) begin
            gen_next[i] = gen_reg[i];
        end
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        prod_next       = prod_reg;
        kind_next       = kind_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pct_next        = pct_reg;
        word_next       = word_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        out_word_next   = out_word_reg;
        out_ranged_next = out_ranged_reg;
        out_hit_next    = out_hit_reg;
        m_tvalid_next   = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            xoshiro_pkg::ST_SEED_ADD: begin
                acc_next   = seed_sum;
                mul_a_next = seed_sum ^ (seed_sum >> 30);
                mul_b_next = xoshiro_pkg::MIX_MUL_A;
                prod_next  = '0;
                cnt_next   = '0;
                state_next = xoshiro_pkg::ST_MUL_A;
            end
            xoshiro_pkg::ST_MUL_A, xoshiro_pkg::ST_MUL_B: begin
                if (mul_b_reg[0]) begin
                    prod_next = prod_reg + mul_a_reg;
                end
                mul_a_next = {mul_a_reg[62:0], 1'b0};
                mul_b_next = {1'b0, mul_b_reg[63:1]};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == xoshiro_pkg::ITER_LAST) begin
                    state_next = (state_reg == xoshiro_pkg::ST_MUL_A) ?
                                 xoshiro_pkg::ST_MIX_B : xoshiro_pkg::ST_MIX_OUT;
                end
            end
            xoshiro_pkg::ST_MIX_B: begin
                mul_a_next = mix_word;
                mul_b_next = xoshiro_pkg::MIX_MUL_B;
                prod_next  = '0;
                cnt_next   = '0;
                state_next = xoshiro_pkg::ST_MUL_B;
            end
            xoshiro_pkg::ST_MIX_OUT: begin
                gen_next[idx_reg] = prod_reg ^ (prod_reg >> 31);
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == xoshiro_pkg::WORD_LAST) ?
                             xoshiro_pkg::ST_IDLE : xoshiro_pkg::ST_SEED_ADD;
            end
            xoshiro_pkg::ST_IDLE: begin
                if (accept) begin
                    kind_next   = s_tuser;
                    lo_next     = s_tdata[31:0];
                    hi_next     = s_tdata[63:32];
                    pct_next    = s_tdata[71:64];
                    // w1 * 5 before the state update
                    word_next   = gen_reg[1] + {gen_reg[1][61:0], 2'b00};
                    gen_next[0] = gen_reg[0] ^ g3_mix;
                    gen_next[1] = gen_reg[1] ^ gen_reg[2] ^ gen_reg[0];
                    gen_next[2] = gen_reg[2] ^ gen_reg[0] ^ {gen_reg[1][46:0], 17'd0};
                    gen_next[3] = {g3_mix[18:0], g3_mix[63:19]};
                    state_next  = xoshiro_pkg::ST_SCRAMBLE;
                end
            end
            xoshiro_pkg::ST_SCRAMBLE: begin
                word_next = rot_word + {rot_word[60:0], 3'b000};
                dvd_next  = rot_word + {rot_word[60:0], 3'b000};
                rem_next  = '0;
                cnt_next  = '0;
                if (kind_reg == xoshiro_pkg::KIND_RANGE) begin
                    divisor_next = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg} + 33'd1;
                    state_next   = ($signed(lo_reg) >= $signed(hi_reg)) ?
                                   xoshiro_pkg::ST_DONE : xoshiro_pkg::ST_DIV;
                end else if (kind_reg == xoshiro_pkg::KIND_PERCENT) begin
                    divisor_next = xoshiro_pkg::PERCENT_SPAN;
                    state_next   = xoshiro_pkg::ST_DIV;
                end else begin
                    state_next = xoshiro_pkg::ST_DONE;
                end
            end
            xoshiro_pkg::ST_DIV: begin
                // restoring remainder step
                rem_next = div_diff[34] ? div_shift[32:0] : div_diff[32:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == xoshiro_pkg::ITER_LAST) begin
                    state_next = xoshiro_pkg::ST_DONE;
                end
            end
            xoshiro_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_word_next   = word_reg;
                    out_ranged_next = '0;
                    out_hit_next    = 1'b0;
                    if (kind_reg == xoshiro_pkg::KIND_RANGE) begin
                        out_ranged_next = ($signed(lo_reg) >= $signed(hi_reg)) ?
                                          lo_reg : lo_reg + rem_reg[31:0];
                    end else if (kind_reg == xoshiro_pkg::KIND_PERCENT) begin
                        out_hit_next = ({25'd0, pct_reg} > rem_reg);
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = xoshiro_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xoshiro_pkg::ST_IDLE;
            end
        endcase

        // seed write restarts the expansion
        if (seed_wr_en) begin
            acc_next   = seed_wr_data;
            idx_next   = '0;
            state_next = xoshiro_pkg::ST_SEED_ADD;
        end
    end

    a_accept_to_scramble: assert property (@(posedge aclk) disable iff (!aresetn || seed_wr_en)
        accept |=> (state_reg == xoshiro_pkg::ST_SCRAMBLE))
        else $error("accepted beat did not move to scramble");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == xoshiro_pkg::ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    a_expand_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn || seed_wr_en)
        ((state_reg == xoshiro_pkg::ST_MIX_OUT) && (idx_reg == xoshiro_pkg::WORD_LAST))
        |=> (state_reg == xoshiro_pkg::ST_IDLE))
        else $error("seed expansion did not finish after last word");

    a_hit_without_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_hit_reg) |-> (out_ranged_reg == 32'd0))
        else $error("chance hit with ranged value set");

endmodule

/* dv/xoshiro256ss_random_generator_checker.sv */
// checker for the xoshiro256** random generator: watches the seed port and both streams,
// predicts every result beat and compares it with what the block delivers
// depends on xoshiro_pkg for widths and the splitmix64 and kind constants
`timescale 1ns / 1ps

module xoshiro256ss_random_generator_checker
    import xoshiro_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         seed_wr_en,
    input  logic [63:0]  seed_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,    // low_bound[31:0], high_bound[63:32], percent[71:64]
    input  logic [1:0]   s_tuser,    // kind[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,    // random_word[63:0], ranged_value[95:64], chance_hit[96]
    output int unsigned  draws_pending,
    output int unsigned  fail_count,
    output int unsigned  draws_checked
);

    localparam int unsigned SHIFT_T    = 17;
    localparam int unsigned ROT_S3     = 45;
    localparam int unsigned REPORT_CAP = 60;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [BOUND_W-1:0] ranged;
        logic               hit;
    } draw_t;

    logic [WORD_W-1:0] gen_words [4];
    draw_t             draws_due [$];

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic void load_seed(input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] z;
        acc = value;
        for (int i = 0; i < 4; i++) begin
            acc = acc + GOLDEN_STEP;
            z = (acc ^ (acc >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            gen_words[i] = z ^ (z >> 31);
        end
    endfunction

    function automatic logic [WORD_W-1:0] advance_generator();
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] t;
        word = rotl64(gen_words[1] * 64'd5, 7) * 64'd9;
        t = gen_words[1] << SHIFT_T;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ t;
        gen_words[3] = rotl64(gen_words[3], ROT_S3);
        return word;
    endfunction

    function automatic draw_t predict_draw(input logic [KIND_W-1:0] kind,
                                           input logic [BOUND_W-1:0] lo,
                                           input logic [BOUND_W-1:0] hi,
                                           input logic [PCT_W-1:0] pct);
        draw_t             d;
        logic signed [SPAN_W-1:0] lo_x;
        logic signed [SPAN_W-1:0] hi_x;
        logic [SPAN_W-1:0] span;
        logic [WORD_W-1:0] rem;
        d = '0;
        d.word = advance_generator();
        lo_x = {lo[BOUND_W-1], lo};
        hi_x = {hi[BOUND_W-1], hi};
        case (kind)
            KIND_RANGE: begin
                if (lo_x >= hi_x) begin
                    d.ranged = lo;
                end else begin
                    span = hi_x - lo_x + 33'sd1;
                    rem = d.word % {31'd0, span};
                    d.ranged = lo + rem[BOUND_W-1:0];
                end
            end
            KIND_PERCENT: begin
                rem = d.word % {31'd0, PERCENT_SPAN};
                d.hit = ((rem + 64'd1) <= {56'd0, pct});
            end
            default: ;
        endcase
        return d;
    endfunction

    function automatic bit field_differs(input string name, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
        if (want === got) return 1'b0;
        if (fail_count < REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        draw_t got;
        draw_t want;
        bit    bad;
        int    delta;
        if (!aresetn) begin
            draws_due.delete();
            load_seed(RESET_SEED);
            draws_pending <= 0;
            fail_count    <= 0;
            draws_checked <= 0;
        end else begin
            delta = 0;
            if (seed_wr_en)
                load_seed(seed_wr_data);
            if (m_tvalid && m_tready) begin
                got.word   = m_tdata[63:0];
                got.ranged = m_tdata[95:64];
                got.hit    = m_tdata[96];
                draws_checked <= draws_checked + 1;
                if (draws_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual word %h",
                             $time, got.word);
                    fail_count <= fail_count + 1;
                end else begin
                    want = draws_due.pop_front();
                    delta = delta - 1;
                    bad = 1'b0;
                    bad |= field_differs("random_word", want.word, got.word);
                    bad |= field_differs("ranged_value", {32'd0, want.ranged}, {32'd0, got.ranged});
                    bad |= field_differs("chance_hit", {63'd0, want.hit}, {63'd0, got.hit});
                    if (bad)
                        fail_count <= fail_count + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                draws_due.push_back(predict_draw(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                 s_tdata[71:64]));
                delta = delta + 1;
            end
            draws_pending <= draws_pending + delta;
        end
    end

endmodule

/* dv/xoshiro256ss_random_generator_top_tb.sv */
// testbench top for the xoshiro256** random generator: drives request beats and seed writes,
// throttles the result stream and gives the verdict
// depends on xoshiro_pkg, the block itself and xoshiro256ss_random_generator_checker
`timescale 1ns / 1ps

module xoshiro256ss_random_generator_top_tb;
    import xoshiro_pkg::*;

    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned CYCLE_LIMIT  = 800000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned PHASE_BEATS  = 400;
    localparam int unsigned LONG_HOLD    = 300;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic         aclk         = 1'b0;
    logic         aresetn      = 1'b0;
    logic         seed_wr_en   = 1'b0;
    logic [63:0]  seed_wr_data = '0;
    logic         s_tvalid     = 1'b0;
    logic [71:0]  s_tdata      = '0;
    logic [1:0]   s_tuser      = '0;
    logic         m_tready     = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [103:0] m_tdata;

    int unsigned draws_pending;
    int unsigned fail_count;
    int unsigned draws_checked;
    int unsigned beats_sent    = 0;
    int unsigned seeds_written = 0;
    int unsigned cycle_count   = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    xoshiro256ss_random_generator_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    xoshiro256ss_random_generator_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .seed_wr_en    (seed_wr_en),
        .seed_wr_data  (seed_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .draws_pending (draws_pending),
        .fail_count    (fail_count),
        .draws_checked (draws_checked)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     draws_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, bursts with ready held high, two long hold-offs
    initial begin : result_sink
        int unsigned taken;
        int unsigned gap;
        taken = 0;
        @(posedge aclk);
        forever begin
            if (taken == 500 || taken == 1300)
                gap = LONG_HOLD;
            else if ((taken / 150) % 4 == 3)
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [7:0] pct);
        int unsigned gap;
        gap = ((beats_sent / 100) % 5 == 4) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pct, hi, lo};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (draws_pending != 0 || !s_tready) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        drain_results();
        seed_wr_en   <= 1'b1;
        seed_wr_data <= value;
        @(posedge aclk);
        seed_wr_en <= 1'b0;
        seeds_written++;
    endtask

    task automatic random_beat();
        logic [KIND_W-1:0] kind;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [7:0]        pct;
        int unsigned       pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            kind = KIND_RAW;
        else if (pick < 6)
            kind = KIND_RANGE;
        else if (pick < 9)
            kind = KIND_PERCENT;
        else
            kind = KIND_UNUSED;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 4))
            0: ;
            1: hi = lo + $urandom_range(1, 20);
            2: hi = lo + $urandom_range(1, 1000);
            3: begin
                lo = $urandom_range(0, 1) ? 32'h8000_0000 : lo;
                hi = $urandom_range(0, 1) ? 32'h7fff_ffff : hi;
            end
            default: hi = lo - $urandom_range(0, 3);
        endcase
        pct = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 101));
        send_beat(kind, lo, hi, pct);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset seed: field extremes, every kind, empty and inverted ranges
        send_beat(KIND_RAW, 32'h0, 32'h0, 8'd0);
        send_beat(KIND_RAW, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
        send_beat(KIND_UNUSED, 32'h8000_0000, 32'h7fff_ffff, 8'd100);
        send_beat(KIND_RANGE, 32'h8000_0000, 32'h7fff_ffff, 8'd0);
        send_beat(KIND_RANGE, 32'h0, 32'h1, 8'd0);
        send_beat(KIND_RANGE, 32'hffff_ffff, 32'h0, 8'd0);
        send_beat(KIND_RANGE, 32'd5, 32'd5, 8'd0);
        send_beat(KIND_RANGE, 32'h7fff_ffff, 32'h8000_0000, 8'd0);
        send_beat(KIND_RANGE, 32'd10, 32'd3, 8'd0);
        send_beat(KIND_RANGE, 32'h8000_0000, 32'h8000_0001, 8'd0);
        send_beat(KIND_RANGE, 32'h7fff_fffe, 32'h7fff_ffff, 8'd0);
        send_beat(KIND_RANGE, -32'sd100, 32'd100, 8'd0);
        send_beat(KIND_RANGE, 32'h0, 32'h7fff_ffff, 8'hff);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd0);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd1);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd50);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd99);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd100);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd101);
        send_beat(KIND_PERCENT, 32'h0, 32'h0, 8'd255);
        send_beat(KIND_PERCENT, 32'h1234_5678, 32'h8765_4321, 8'd60);

        write_seed(64'd0);
        send_beat(KIND_RAW, 32'h0, 32'h0, 8'd0);
        repeat (PHASE_BEATS) random_beat();

        write_seed('1);
        send_beat(KIND_RANGE, 32'h8000_0000, 32'h7fff_ffff, 8'd0);
        repeat (PHASE_BEATS) random_beat();

        write_seed({$urandom, $urandom});
        repeat (PHASE_BEATS / 2) random_beat();
        drain_results();
        repeat (PHASE_BEATS / 2) random_beat();

        write_seed(64'd1);
        repeat (PHASE_BEATS) random_beat();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d request beats over %0d seed settings besides reset, %0d results checked",
                 beats_sent, seeds_written, draws_checked);
        $display("raw, ranged, percent and unused kinds with random stalls on both streams");
        if (fail_count == 0 && draws_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
